// File: rtl/stt_pkg.sv
// Shared types and codes for the second timer table.
`default_nettype none

package stt_pkg;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_DEL     = 2'd1,
        OP_RESTART = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    localparam logic EV_DONE    = 1'b0;
    localparam logic EV_EXPIRED = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_FULL    = 1'b1;

    // One timer entry as held in the slot memory.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] timeout;
        logic        never;
        logic        notify;
        logic [15:0] elapsed;
    } slot_entry_t;

    // Captured request word.
    typedef struct packed {
        op_t         op;
        logic [15:0] timer_id;
        logic [15:0] timeout_secs;
        logic        never_expires;
        logic        send_notice;
    } req_t;

    // What the slot unit wants done for the slot under evaluation.
    typedef struct packed {
        logic        wr_en;
        logic        set_valid;
        logic        clr_valid;
        logic        take_hit;
        logic        emit;
        slot_entry_t wr_data;
    } slot_act_t;

endpackage : stt_pkg

`default_nettype wire

// File: rtl/stt_channels.sv
// Handshake channel interfaces: request, response and configuration.
`default_nettype none

interface stt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] timer_id;
    logic [15:0] timeout_secs;
    logic        never_expires;
    logic        send_notice;

    modport source (output valid, op, timer_id, timeout_secs, never_expires, send_notice,
                    input ready);
    modport sink   (input valid, op, timer_id, timeout_secs, never_expires, send_notice,
                    output ready);
endinterface : stt_req_if

interface stt_rsp_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic        status;
    logic [15:0] expired_id;
    logic        notice_wanted;
    logic        last;

    modport source (output valid, event_kind, status, expired_id, notice_wanted, last,
                    input ready);
    modport sink   (input valid, event_kind, status, expired_id, notice_wanted, last,
                    output ready);
endinterface : stt_rsp_if

interface stt_cfg_if;
    logic valid;
    logic ready;
    logic ticks_enabled;

    modport source (output valid, ticks_enabled, input ready);
    modport sink   (input valid, ticks_enabled, output ready);
endinterface : stt_cfg_if

`default_nettype wire

// File: rtl/second_timer_table.sv
// One request at a time: a new request is accepted only once the sequencer is back in idle,
// after the done word is loaded. The sequencer walks the slot memory one slot per cycle,
// while the response port does not stall, through its single read port, for every operation.
// A stalled response port holds the walk; expiry words wait in the output register.
// Reset clears all valid flags and sets ticks_enabled; slot contents need no clearing pass.
`default_nettype none

module second_timer_table #(
    parameter int TIMER_SLOTS = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stt_req_if.sink    req,
    stt_rsp_if.source  rsp,
    stt_cfg_if.sink    cfg
);
    import stt_pkg::*;

    localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TIMER_SLOTS - 1);

    state_t              state_reg, state_next;
    req_t                req_q_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic                hit_reg;
    logic                ten_reg;

    logic                out_valid_reg;
    logic                out_kind_reg;
    logic                out_status_reg;
    logic [15:0]         out_id_reg;
    logic                out_notice_reg;
    logic                out_last_reg;

    logic                accept;
    logic                stall;
    logic                scan_go;
    logic                last_slot;
    logic                load_expiry;
    logic                load_done;
    logic [ADDR_W-1:0]   rd_addr;
    slot_entry_t         cur_entry;
    logic                cur_valid;
    slot_act_t           act;

    // Configuration: always ready; to be written only while idle, which the block itself does not enforce.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ten_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            ten_reg <= cfg.ticks_enabled;
        end
    end

    assign stall     = out_valid_reg && !rsp.ready;
    assign last_slot = (idx_reg == LAST_SLOT);

    // FSM next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stall && last_slot)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        scan_go   = 1'b0;
        load_done = 1'b0;
        rd_addr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
            end
            S_SCAN:
            begin
                scan_go = !stall;
                // read one slot ahead; on a stall re-read the current slot
                rd_addr = (!stall && !last_slot) ? idx_reg + 1'b1 : idx_reg;
            end
            S_FINISH:
            begin
                load_done = !stall;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign accept      = req.valid && req.ready;
    assign load_expiry = scan_go && act.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (scan_go)
            begin
                if (!last_slot)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (act.take_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_q_reg.op            <= op_t'(req.op);
            req_q_reg.timer_id      <= req.timer_id;
            req_q_reg.timeout_secs  <= req.timeout_secs;
            req_q_reg.never_expires <= req.never_expires;
            req_q_reg.send_notice   <= req.send_notice;
        end
    end

    stt_slot_store #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (scan_go && act.wr_en),
        .set_valid (scan_go && act.set_valid),
        .clr_valid (scan_go && act.clr_valid),
        .cur_addr  (idx_reg),
        .wr_data   (act.wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (cur_entry),
        .cur_valid (cur_valid)
    );

    stt_slot_unit u_unit (
        .req       (req_q_reg),
        .cur       (cur_entry),
        .cur_valid (cur_valid),
        .hit       (hit_reg),
        .ticks_en  (ten_reg),
        .act       (act)
    );

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_expiry || load_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_expiry)
        begin
            out_kind_reg   <= EV_EXPIRED;
            out_status_reg <= ST_OK;
            out_id_reg     <= cur_entry.id;
            out_notice_reg <= cur_entry.notify;
            out_last_reg   <= 1'b0;
        end
        else if (load_done)
        begin
            out_kind_reg   <= EV_DONE;
            out_status_reg <= (req_q_reg.op == OP_ADD && !hit_reg) ? ST_FULL : ST_OK;
            out_id_reg     <= '0;
            out_notice_reg <= 1'b0;
            out_last_reg   <= 1'b1;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.event_kind    = out_kind_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.expired_id    = out_id_reg;
    assign rsp.notice_wanted = out_notice_reg;
    assign rsp.last          = out_last_reg;

endmodule : second_timer_table

`default_nettype wire

// File: rtl/stt_slot_store.sv
// Slot memory with registered read and per-slot valid flags.
`default_nettype none

module stt_slot_store #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic                set_valid,
    input  logic                clr_valid,
    input  logic [ADDR_W-1:0]   cur_addr,
    input  stt_pkg::slot_entry_t wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output stt_pkg::slot_entry_t rd_data,
    output logic                cur_valid
);
    import stt_pkg::*;

    slot_entry_t       slot_mem [DEPTH];
    slot_entry_t       rd_data_reg;
    logic [DEPTH-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[cur_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (set_valid)
        begin
            valid_reg[cur_addr] <= 1'b1;
        end
        else if (clr_valid)
        begin
            valid_reg[cur_addr] <= 1'b0;
        end
    end

    assign rd_data   = rd_data_reg;
    assign cur_valid = valid_reg[cur_addr];

endmodule : stt_slot_store

`default_nettype wire

// File: rtl/stt_slot_unit.sv
// Shared per-slot unit: id compare, free test, saturating count and expiry compare.
`default_nettype none

module stt_slot_unit (
    input  stt_pkg::req_t        req,
    input  stt_pkg::slot_entry_t cur,
    input  logic                 cur_valid,
    input  logic                 hit,
    input  logic                 ticks_en,
    output stt_pkg::slot_act_t   act
);
    import stt_pkg::*;

    logic        same_id;
    logic [15:0] elapsed_inc;

    assign same_id     = (cur.id == req.timer_id);
    assign elapsed_inc = (cur.elapsed == 16'hFFFF) ? cur.elapsed : cur.elapsed + 16'd1;

    always_comb
    begin
        act         = '0;
        act.wr_data = cur;
        unique case (req.op)
            OP_ADD:
            begin
                if (!cur_valid && !hit)
                begin
                    act.wr_en           = 1'b1;
                    act.set_valid       = 1'b1;
                    act.take_hit        = 1'b1;
                    act.wr_data.id      = req.timer_id;
                    act.wr_data.timeout = req.timeout_secs;
                    act.wr_data.never   = req.never_expires;
                    act.wr_data.notify  = req.send_notice;
                    act.wr_data.elapsed = '0;
                end
            end
            OP_DEL:
            begin
                if (cur_valid && same_id && !hit)
                begin
                    act.clr_valid = 1'b1;
                    act.take_hit  = 1'b1;
                end
            end
            OP_RESTART:
            begin
                if (cur_valid && same_id && !hit)
                begin
                    act.wr_en           = 1'b1;
                    act.take_hit        = 1'b1;
                    act.wr_data.elapsed = '0;
                end
            end
            OP_TICK:
            begin
                if (ticks_en && cur_valid)
                begin
                    act.wr_en           = 1'b1;
                    act.wr_data.elapsed = elapsed_inc;
                    act.emit            = !cur.never && (elapsed_inc >= cur.timeout);
                end
            end
            default:
            begin
                act.wr_en = 1'b0;
            end
        endcase
    end

endmodule : stt_slot_unit

`default_nettype wire
